FILE: rtl/lpm_pkg.sv
package lpm_pkg;

  // default table depth
  localparam int DEFAULT_ENTRIES = 16;

  // longest prefix an ipv4 address can carry
  localparam int MAX_PREFIX = 32;

  // field widths
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int OUT_IDX_W = 4;

  // operation carried with each input transaction
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  // result code returned with each output transaction
  typedef enum logic [1:0] {
    RES_MATCH   = 2'd0,
    RES_DEFAULT = 2'd1,
    RES_NONE    = 2'd2,
    RES_DONE    = 2'd3
  } result_t;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_WIPE,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic cnt_clear;
    logic cnt_step;
    logic wipe;
    logic mem_write;
    logic read_issue;
    logic search_init;
    logic result_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    cnt_last;
    logic    out_free;
  } status_t;

endpackage

FILE: rtl/lpm_ctrl.sv
module lpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  lpm_pkg::status_t  status,
  output lpm_pkg::cmd_t     cmd
);

  lpm_pkg::state_t state;
  lpm_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpm_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpm_pkg::ST_INIT: begin
        if (status.cnt_last) state_next = lpm_pkg::ST_IDLE;
      end
      lpm_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = lpm_pkg::ST_EXEC;
      end
      lpm_pkg::ST_EXEC: begin
        unique case (status.op)
          lpm_pkg::OP_LOOKUP: state_next = lpm_pkg::ST_SCAN;
          lpm_pkg::OP_CLEAR:  state_next = lpm_pkg::ST_WIPE;
          default:            state_next = lpm_pkg::ST_FINISH;
        endcase
      end
      lpm_pkg::ST_SCAN: begin
        if (status.cnt_last) state_next = lpm_pkg::ST_DRAIN;
      end
      lpm_pkg::ST_DRAIN: begin
        state_next = lpm_pkg::ST_FINISH;
      end
      lpm_pkg::ST_WIPE: begin
        if (status.cnt_last) state_next = lpm_pkg::ST_FINISH;
      end
      lpm_pkg::ST_FINISH: begin
        if (status.out_free) state_next = lpm_pkg::ST_IDLE;
      end
      default: begin
        state_next = lpm_pkg::ST_INIT;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state) inside
      lpm_pkg::ST_INIT, lpm_pkg::ST_WIPE: begin
        cmd.wipe      = 1'b1;
        cmd.cnt_step  = !status.cnt_last;
        cmd.cnt_clear = status.cnt_last;
      end
      lpm_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      lpm_pkg::ST_EXEC: begin
        cmd.mem_write   = (status.op == lpm_pkg::OP_WRITE);
        cmd.search_init = (status.op == lpm_pkg::OP_LOOKUP);
      end
      lpm_pkg::ST_SCAN: begin
        cmd.read_issue = 1'b1;
        cmd.cnt_step   = !status.cnt_last;
        cmd.cnt_clear  = status.cnt_last;
      end
      lpm_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      lpm_pkg::ST_FINISH: begin
        cmd.result_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/lpm_dp.sv
module lpm_dp #(
  parameter int ENTRIES = lpm_pkg::DEFAULT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  lpm_pkg::cmd_t     cmd,
  output lpm_pkg::status_t  status,
  input  logic [1:0]        in_opcode,
  input  logic [3:0]        in_entry_index,
  input  logic [31:0]       in_prefix_address,
  input  logic [5:0]        in_prefix_length,
  input  logic [31:0]       in_lookup_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_result_code,
  output logic [3:0]        out_best_index,
  output logic [5:0]        out_matched_length
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W = 1 + lpm_pkg::LEN_W + lpm_pkg::ADDR_W;

  // table memory: {valid, length, address}
  logic [ROW_W-1:0] mem [ENTRIES];

  // captured transaction
  lpm_pkg::opcode_t         op;
  logic [IDX_W-1:0]         wr_idx;
  logic                     in_range;
  logic [lpm_pkg::ADDR_W-1:0] paddr;
  logic [lpm_pkg::LEN_W-1:0]  plen;
  logic [lpm_pkg::ADDR_W-1:0] laddr;

  // sweep counter and read stage
  logic [IDX_W-1:0]         cnt;
  logic                     rd_pending;
  logic [IDX_W-1:0]         rd_idx;
  logic [ROW_W-1:0]         rd_data;

  // search state
  logic                     found;
  logic [IDX_W-1:0]         best_idx;
  logic [lpm_pkg::LEN_W-1:0] best_len;
  logic                     have_def;
  logic [IDX_W-1:0]         def_idx;

  // compare signals
  logic                      rd_v;
  logic [lpm_pkg::LEN_W-1:0] rd_len;
  logic [lpm_pkg::ADDR_W-1:0] rd_addr;
  logic [lpm_pkg::ADDR_W-1:0] rd_mask;
  logic                      rd_hit;

  // result staging
  lpm_pkg::result_t          res_code;
  logic [IDX_W-1:0]          res_idx;
  logic [lpm_pkg::LEN_W-1:0] res_len;
  logic [ROW_W-1:0]          wr_row;
  logic [IDX_W-1:0]          wr_addr;

  // capture the input transaction, clamping the length
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= lpm_pkg::opcode_t'(in_opcode);
      wr_idx   <= IDX_W'(in_entry_index);
      in_range <= (32'(in_entry_index) < 32'(ENTRIES));
      paddr    <= in_prefix_address;
      plen     <= (in_prefix_length > 6'(lpm_pkg::MAX_PREFIX)) ?
                  6'(lpm_pkg::MAX_PREFIX) : in_prefix_length;
      laddr    <= in_lookup_address;
    end
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.cnt_step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // memory write port: wipe clears the valid bit, write stores an entry
  always_comb begin
    wr_row  = cmd.wipe ? '0 : {1'b1, plen, paddr};
    wr_addr = cmd.wipe ? cnt : wr_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.wipe || (cmd.mem_write && in_range)) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      rd_data <= mem[cnt];
      rd_idx  <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.read_issue;
    end
  end

  // masked prefix compare
  always_comb begin
    rd_v    = rd_data[ROW_W-1];
    rd_len  = rd_data[lpm_pkg::ADDR_W +: lpm_pkg::LEN_W];
    rd_addr = rd_data[lpm_pkg::ADDR_W-1:0];
    rd_mask = ~(32'hFFFF_FFFF >> rd_len);
    rd_hit  = (((laddr ^ rd_addr) & rd_mask) == '0);
  end

  // best match and last default tracking
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      found    <= 1'b0;
      have_def <= 1'b0;
      best_idx <= '0;
      best_len <= '0;
      def_idx  <= '0;
    end else if (rd_pending && rd_v) begin
      if (rd_len == '0) begin
        have_def <= 1'b1;
        def_idx  <= rd_idx;
      end else if (rd_hit && (!found || (rd_len > best_len))) begin
        found    <= 1'b1;
        best_idx <= rd_idx;
        best_len <= rd_len;
      end
    end
  end

  // result selection
  always_comb begin
    res_code = lpm_pkg::RES_DONE;
    res_idx  = '0;
    res_len  = '0;
    if (op == lpm_pkg::OP_LOOKUP) begin
      if (found) begin
        res_code = lpm_pkg::RES_MATCH;
        res_idx  = best_idx;
        res_len  = best_len;
      end else if (have_def) begin
        res_code = lpm_pkg::RES_DEFAULT;
        res_idx  = def_idx;
      end else begin
        res_code = lpm_pkg::RES_NONE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_result_code    <= res_code;
      out_best_index     <= 4'(res_idx);
      out_matched_length <= res_len;
    end
  end

  // status to controller
  always_comb begin
    status.op       = op;
    status.cnt_last = (cnt == IDX_W'(ENTRIES - 1));
    status.out_free = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  // a found match always has a nonzero length
  assert property (@(posedge clk) disable iff (rst)
    found |-> (best_len != '0))
    else $error("match recorded with zero length");

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // only a prefix match reports a nonzero length
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_result_code != lpm_pkg::RES_MATCH)) |->
      (out_matched_length == '0))
    else $error("length reported without a prefix match");

  // a read is always followed by its evaluation slot
  assert property (@(posedge clk) disable iff (rst)
    cmd.read_issue |=> rd_pending)
    else $error("table read lost");
`endif

endmodule

FILE: rtl/longest_prefix_match_table.sv
// IPv4 longest prefix match table. Each input transaction writes one entry,
// clears the table, looks up an address or does nothing (OP_NOP), and gives
// exactly one result. The table sits in a single memory with one read port; a
// lookup scans it one entry per cycle. A clear sweeps the valid bits of every
// entry. After reset the same sweep runs before the first transaction is
// accepted. One transaction is in work at a time; a finished result waits in
// the output register while the next transaction is accepted.
module longest_prefix_match_table #(
  parameter int ENTRIES = lpm_pkg::DEFAULT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index[3:0], prefix_address[35:4], prefix_length[41:36],
  // lookup_address[73:42], zero fill [79:74]
  input  logic [79:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // match_slot[3:0], matched_length[9:4], zero fill [15:10]
  output logic [15:0] m_tdata,
  // result_code[1:0]
  output logic [1:0]  m_tuser
);

  lpm_pkg::cmd_t    cmd;
  lpm_pkg::status_t status;
  logic [3:0]       match_slot;
  logic [5:0]       matched_length;

  // controller
  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath with table memory
  lpm_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .in_opcode          (s_tuser),
    .in_entry_index     (s_tdata[3:0]),
    .in_prefix_address  (s_tdata[35:4]),
    .in_prefix_length   (s_tdata[41:36]),
    .in_lookup_address  (s_tdata[73:42]),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_result_code    (m_tuser),
    .out_best_index     (match_slot),
    .out_matched_length (matched_length)
  );

  // pack result fields
  assign m_tdata = {6'd0, matched_length, match_slot};

endmodule

FILE: tb/sv/testbench.sv
module testbench;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  // one result as the block returns it
  typedef struct packed {
    lpm_pkg::result_t code;
    logic [3:0]       idx;
    logic [5:0]       len;
  } lpm_result_t;

  // expectation source for one accepted transaction
  typedef struct packed {
    bit          pinned;
    lpm_result_t res;
  } row_check_t;

  // one row of the directed table
  typedef struct packed {
    lpm_pkg::opcode_t op;
    logic [3:0]       idx;
    logic [31:0]      paddr;
    logic [5:0]       plen;
    logic [31:0]      laddr;
    bit               pinned;
    lpm_result_t      res;
  } stim_row_t;

  localparam lpm_result_t NO_RES   = '{lpm_pkg::RES_DONE, 4'd0, 6'd0};
  localparam lpm_result_t DONE_RES = '{lpm_pkg::RES_DONE, 4'd0, 6'd0};
  localparam lpm_result_t NONE_RES = '{lpm_pkg::RES_NONE, 4'd0, 6'd0};

  // directed rows: extremes, host bits, ties, long lengths, defaults, clear
  localparam int DIRECTED_ROWS = 25;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'hFFFF_FFFF, 1'b1, NONE_RES},
    '{lpm_pkg::OP_WRITE,  4'd0,  32'h0A00_0000, 6'd8,  32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_WRITE,  4'd15, 32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h0A12_3456, 1'b0, NO_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'hFFFF_FFFF, 1'b0, NO_RES},
    '{lpm_pkg::OP_WRITE,  4'd1,  32'h0A12_FFFF, 6'd16, 32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h0A12_0000, 1'b0, NO_RES},
    '{lpm_pkg::OP_WRITE,  4'd2,  32'h0A12_0000, 6'd16, 32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h0A12_ABCD, 1'b0, NO_RES},
    '{lpm_pkg::OP_WRITE,  4'd3,  32'h0000_0000, 6'd63, 32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h0000_0000, 1'b0, NO_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h8000_0000, 1'b1, NONE_RES},
    '{lpm_pkg::OP_WRITE,  4'd5,  32'h1234_5678, 6'd0,  32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_WRITE,  4'd9,  32'hDEAD_BEEF, 6'd0,  32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h8000_0000, 1'b0, NO_RES},
    '{lpm_pkg::OP_WRITE,  4'd7,  32'hC0A8_0000, 6'd33, 32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'hC0A8_0000, 1'b0, NO_RES},
    '{lpm_pkg::OP_NOP,    4'd15, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1, DONE_RES},
    '{lpm_pkg::OP_WRITE,  4'd4,  32'h8000_0000, 6'd1,  32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'hFFFF_FFFE, 1'b0, NO_RES},
    '{lpm_pkg::OP_CLEAR,  4'd0,  32'h0000_0000, 6'd0,  32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h0A00_0000, 1'b1, NONE_RES},
    '{lpm_pkg::OP_WRITE,  4'd0,  32'h0000_0000, 6'd0,  32'h0000_0000, 1'b1, DONE_RES},
    '{lpm_pkg::OP_LOOKUP, 4'd0,  32'h0000_0000, 6'd0,  32'h1234_5678, 1'b1,
      '{lpm_pkg::RES_DEFAULT, 4'd0, 6'd0}},
    '{lpm_pkg::OP_CLEAR,  4'd0,  32'h0000_0000, 6'd0,  32'h0000_0000, 1'b1, DONE_RES}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = lpm_pkg::OP_NOP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  // predictor copy of the prefix table
  logic [31:0] route_addr  [lpm_pkg::DEFAULT_ENTRIES];
  logic [5:0]  route_len   [lpm_pkg::DEFAULT_ENTRIES];
  bit          route_valid [lpm_pkg::DEFAULT_ENTRIES];

  lpm_result_t pending_results [$];
  row_check_t  row_checks [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          hold_output = 1'b0;
  logic [31:0] sent_prefixes [lpm_pkg::DEFAULT_ENTRIES];

  longest_prefix_match_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // apply one transaction to the table and return its answer
  function automatic lpm_result_t route_update(lpm_pkg::opcode_t op, logic [3:0] idx,
                                               logic [31:0] paddr, logic [5:0] plen,
                                               logic [31:0] laddr);
    lpm_result_t res;
    bit          found;
    bit          have_default;
    logic [3:0]  default_idx;
    logic [31:0] mask;
    res = DONE_RES;
    found = 1'b0;
    have_default = 1'b0;
    default_idx = '0;
    case (op)
      lpm_pkg::OP_WRITE: begin
        route_addr[idx]  = paddr;
        route_len[idx]   = (plen > lpm_pkg::MAX_PREFIX) ?
                           lpm_pkg::LEN_W'(lpm_pkg::MAX_PREFIX) : plen;
        route_valid[idx] = 1'b1;
      end
      lpm_pkg::OP_CLEAR: begin
        for (int i = 0; i < lpm_pkg::DEFAULT_ENTRIES; i++) route_valid[i] = 1'b0;
      end
      lpm_pkg::OP_LOOKUP: begin
        for (int i = 0; i < lpm_pkg::DEFAULT_ENTRIES; i++) begin
          if (route_valid[i]) begin
            if (route_len[i] == 0) begin
              have_default = 1'b1;
              default_idx = i[3:0];
            end else begin
              mask = 32'hFFFF_FFFF << (lpm_pkg::MAX_PREFIX - route_len[i]);
              if ((((laddr ^ route_addr[i]) & mask) == 0) &&
                  (!found || route_len[i] > res.len)) begin
                found = 1'b1;
                res.len = route_len[i];
                res.idx = i[3:0];
              end
            end
          end
        end
        if (found) res.code = lpm_pkg::RES_MATCH;
        else if (have_default) res = '{lpm_pkg::RES_DEFAULT, default_idx, 6'd0};
        else res = NONE_RES;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // offer one transaction and wait for it to be accepted
  task automatic offer_item(lpm_pkg::opcode_t op, logic [3:0] idx, logic [31:0] paddr,
                            logic [5:0] plen, logic [31:0] laddr, bit pinned,
                            lpm_result_t res);
    int         gap;
    row_check_t chk;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chk = '{pinned, res};
    row_checks.insert(row_checks.size(), chk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, laddr, plen, paddr, idx};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (op == lpm_pkg::OP_WRITE) sent_prefixes[idx] = paddr;
  endtask

  // prediction, checking and watchdog on every edge
  always @(posedge clk) begin
    row_check_t  chk;
    lpm_result_t pred;
    lpm_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pred = route_update(lpm_pkg::opcode_t'(s_tuser), s_tdata[3:0], s_tdata[35:4],
                            s_tdata[41:36], s_tdata[73:42]);
        chk = row_checks.pop_front();
        pending_results.insert(pending_results.size(), chk.pinned ? chk.res : pred);
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, code", m_tuser, -1);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser != want.code) report_mismatch("result_code", m_tuser, want.code);
          if (m_tdata[3:0] != want.idx) report_mismatch("match_slot", m_tdata[3:0], want.idx);
          if (m_tdata[9:4] != want.len)
            report_mismatch("matched_length", m_tdata[9:4], want.len);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transaction for %0d cycles", IDLE_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // output side: random stalls, bursts and one long hold-off
  initial begin
    int gap;
    int rx_count;
    rx_count = 0;
    wait (!rst);
    forever begin
      if (hold_output) begin
        gap = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      rx_count++;
      if (rx_count % 40 == 0) rx_burst = 1'($urandom_range(0, 1));
    end
  end

  // input side: directed table, then random traffic
  initial begin
    lpm_pkg::opcode_t op;
    logic [3:0]       idx;
    logic [31:0]      paddr;
    logic [5:0]       plen;
    logic [31:0]      laddr;
    int               pick;
    for (int i = 0; i < lpm_pkg::DEFAULT_ENTRIES; i++) begin
      route_valid[i] = 1'b0;
      route_addr[i] = '0;
      route_len[i] = '0;
    end
    sent_prefixes = '{32'h0A00_0000, 32'hC0A8_0100, 32'hAC10_0000, 32'h0000_0000,
                      32'hFFFF_FFFF, 32'h8000_0000, 32'h7F00_0001, 32'h0A0A_0A0A,
                      32'hDEAD_BEEF, 32'h1234_5678, 32'hC0A8_0000, 32'h0A12_0000,
                      32'hE000_0000, 32'h6400_0000, 32'hFE80_0000, 32'h5555_AAAA};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      offer_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].paddr,
                 directed_rows[r].plen, directed_rows[r].laddr,
                 directed_rows[r].pinned, directed_rows[r].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) tx_burst = 1'($urandom_range(0, 1));
      if (n == 120) hold_output = 1'b1;
      // let everything drain before carrying on
      if (n == 260) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      idx   = 4'($urandom_range(0, 15));
      paddr = $urandom;
      plen  = 6'($urandom_range(0, 63));
      laddr = $urandom;
      pick  = $urandom_range(0, 99);
      if (pick < 40) begin
        op = lpm_pkg::OP_WRITE;
        pick = $urandom_range(0, 99);
        if (pick < 5) plen = 6'd0;
        else if (pick < 12) plen = 6'($urandom_range(lpm_pkg::MAX_PREFIX + 1, 63));
        else plen = 6'($urandom_range(1, lpm_pkg::MAX_PREFIX));
        // nested prefixes share the high bits of an earlier one
        if ($urandom_range(0, 1))
          paddr = sent_prefixes[$urandom_range(0, 15)] ^ ($urandom >> $urandom_range(0, 32));
      end else if (pick < 90) begin
        op = lpm_pkg::OP_LOOKUP;
        if ($urandom_range(0, 9) < 7)
          laddr = sent_prefixes[$urandom_range(0, 15)] ^ ($urandom >> $urandom_range(4, 32));
      end else if (pick < 95) begin
        op = lpm_pkg::OP_CLEAR;
      end else begin
        op = lpm_pkg::OP_NOP;
      end
      offer_item(op, idx, paddr, plen, laddr, 1'b0, NO_RES);
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lpm_pkg.sv
rtl/lpm_ctrl.sv
rtl/lpm_dp.sv
rtl/longest_prefix_match_table.sv
tb/sv/testbench.sv
